// ===== hw/rtl/wsfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfe_pkg
// Shared types, constants and header helpers of the WebSocket frame encoder.
// ----------------------------------------------------------------------------
package wsfe_pkg;

    localparam int LEN_BITS    = 32;
    localparam int KEY_BITS    = 32;
    localparam int LEFT_BITS   = 32;
    localparam int BYTE_BITS   = 8;
    localparam int HDR_MAX     = 14;
    localparam int IDX_BITS    = $clog2(HDR_MAX);
    localparam int S_DATA_BITS = 80;
    localparam int M_DATA_BITS = 8;

    localparam logic [63:0] SHORT_LIMIT  = 64'd126;
    localparam logic [63:0] MEDIUM_LIMIT = 64'd65536;
    localparam logic [6:0]  CODE_MEDIUM  = 7'd126;
    localparam logic [6:0]  CODE_LONG    = 7'd127;

    typedef enum logic [0:0] {
        CMD_BEGIN   = 1'b0,
        CMD_PAYLOAD = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        FMT_SHORT,
        FMT_MEDIUM,
        FMT_LONG
    } len_fmt_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [3:0]            opcode;
        logic                  final_flag;
        logic [31:0]           frame_length;
        logic [KEY_BITS-1:0]   mask_key;
        logic [BYTE_BITS-1:0]  payload_byte;
    } item_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0]  out_byte;
        logic                  last;
        logic                  error;
    } res_t;

    function automatic logic [63:0] ext_length(input logic [31:0] frame_length);
        logic [63:0] mask;
        mask = (64'd1 << LEN_BITS) - 64'd1;
        return {32'd0, frame_length} & mask;
    endfunction

    function automatic len_fmt_t len_fmt(input logic [63:0] len64);
        len_fmt_t f;
        if (len64 < SHORT_LIMIT) begin
            f = FMT_SHORT;
        end else if (len64 < MEDIUM_LIMIT) begin
            f = FMT_MEDIUM;
        end else begin
            f = FMT_LONG;
        end
        return f;
    endfunction

    function automatic logic [IDX_BITS-1:0] hdr_count(input logic [63:0] len64,
                                                      input logic [KEY_BITS-1:0] key);
        logic [IDX_BITS-1:0] n;
        unique case (len_fmt(len64))
            FMT_SHORT:  n = IDX_BITS'(2);
            FMT_MEDIUM: n = IDX_BITS'(4);
            default:    n = IDX_BITS'(10);
        endcase
        if (key != '0) begin
            n = n + IDX_BITS'(4);
        end
        return n;
    endfunction

    function automatic logic [BYTE_BITS-1:0] hdr_byte(input item_t it,
                                                      input logic [IDX_BITS-1:0] idx);
        logic [BYTE_BITS-1:0] b [2**IDX_BITS];
        logic [63:0]          len64;
        logic                 mbit;
        len64 = ext_length(it.frame_length);
        mbit  = (it.mask_key != '0);
        for (int i = 0; i < 2**IDX_BITS; i++) begin
            b[i] = '0;
        end
        b[0] = {it.final_flag, 3'b000, it.opcode};
        unique case (len_fmt(len64))
            FMT_SHORT: begin
                b[1] = {mbit, len64[6:0]};
                for (int i = 0; i < 4; i++) begin
                    b[2+i] = it.mask_key[8*i +: 8];
                end
            end
            FMT_MEDIUM: begin
                b[1] = {mbit, CODE_MEDIUM};
                b[2] = len64[15:8];
                b[3] = len64[7:0];
                for (int i = 0; i < 4; i++) begin
                    b[4+i] = it.mask_key[8*i +: 8];
                end
            end
            default: begin
                b[1] = {mbit, CODE_LONG};
                for (int i = 0; i < 8; i++) begin
                    b[2+i] = len64[8*(7-i) +: 8];
                end
                for (int i = 0; i < 4; i++) begin
                    b[10+i] = it.mask_key[8*i +: 8];
                end
            end
        endcase
        return b[idx];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/wsfe_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfe_in_stage
// Input register: captures one request and holds it until the encoder pops it.
// ----------------------------------------------------------------------------
module wsfe_in_stage (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // opcode[3:0], final_flag[4], frame_length[36:5], mask_key[68:37],
    // payload_byte[76:69], zero fill[79:77]
    input  wire logic [wsfe_pkg::S_DATA_BITS-1:0] s_tdata,
    // cmd[0]
    input  wire logic                             s_tuser,
    output logic                                  item_valid,
    output wsfe_pkg::item_t                       item,
    input  wire logic                             item_pop
);
    import wsfe_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_in;

    assign item_in.cmd          = cmd_t'(s_tuser);
    assign item_in.opcode       = s_tdata[3:0];
    assign item_in.final_flag   = s_tdata[4];
    assign item_in.frame_length = s_tdata[36:5];
    assign item_in.mask_key     = s_tdata[68:37];
    assign item_in.payload_byte = s_tdata[76:69];

    assign s_tready   = !valid_reg || item_pop;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_tvalid && s_tready) begin
            item_reg <= item_in;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/wsfe_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfe_encoder
// Frame state and byte sequencer: walks header bytes, masks payload bytes.
// ----------------------------------------------------------------------------
module wsfe_encoder (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            item_valid,
    input  wire wsfe_pkg::item_t item,
    output logic                 item_pop,
    output logic                 res_valid,
    output wsfe_pkg::res_t       res,
    input  wire logic            res_ready
);
    import wsfe_pkg::*;

    logic [LEFT_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [1:0]           key_index_reg, key_index_next;
    logic [KEY_BITS-1:0]  held_key_reg, held_key_next;
    logic                 frame_open_reg, frame_open_next;
    logic [IDX_BITS-1:0]  idx_reg, idx_next;

    logic [63:0]          len64;
    logic [IDX_BITS-1:0]  hdr_n;
    logic                 hdr_end;
    logic                 fire;
    logic [LEFT_BITS-1:0] left_dec;
    logic [BYTE_BITS-1:0] key_byte;

    assign len64    = ext_length(item.frame_length);
    assign hdr_n    = hdr_count(len64, item.mask_key);
    assign hdr_end  = (idx_reg == hdr_n - IDX_BITS'(1));
    assign left_dec = bytes_left_reg - LEFT_BITS'(1);
    assign key_byte = held_key_reg[8*key_index_reg +: 8];

    assign res_valid = item_valid;
    assign fire      = item_valid && res_ready;

    always_comb begin
        bytes_left_next = bytes_left_reg;
        key_index_next  = key_index_reg;
        held_key_next   = held_key_reg;
        frame_open_next = frame_open_reg;
        idx_next        = idx_reg;
        item_pop        = 1'b0;
        res             = '0;
        unique case (item.cmd)
            CMD_PAYLOAD: begin
                if (!frame_open_reg) begin
                    res.error = 1'b1;
                end else begin
                    res.out_byte = item.payload_byte ^ key_byte;
                    res.last     = (left_dec == '0);
                end
                if (fire) begin
                    item_pop = 1'b1;
                    if (frame_open_reg) begin
                        key_index_next  = key_index_reg + 2'd1;
                        bytes_left_next = left_dec;
                        frame_open_next = (left_dec != '0);
                    end
                end
            end
            default: begin
                res.out_byte = hdr_byte(item, idx_reg);
                res.last     = hdr_end && (len64 == '0);
                if (fire) begin
                    if (hdr_end) begin
                        item_pop        = 1'b1;
                        idx_next        = '0;
                        bytes_left_next = len64[LEFT_BITS-1:0];
                        key_index_next  = '0;
                        held_key_next   = item.mask_key;
                        frame_open_next = (len64 != '0);
                    end else begin
                        idx_next = idx_reg + IDX_BITS'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            key_index_reg  <= '0;
            held_key_reg   <= '0;
            frame_open_reg <= 1'b0;
            idx_reg        <= '0;
        end else begin
            bytes_left_reg <= bytes_left_next;
            key_index_reg  <= key_index_next;
            held_key_reg   <= held_key_next;
            frame_open_reg <= frame_open_next;
            idx_reg        <= idx_next;
        end
    end

    a_idx_only_in_header: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != '0 |-> item_valid && item.cmd == CMD_BEGIN)
        else $error("header index advanced without a begin request");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.error |-> !res.last && res.out_byte == '0 && !frame_open_reg)
        else $error("error result malformed");

    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.last |=> !frame_open_reg && idx_reg == '0)
        else $error("frame still open after last byte");

endmodule
`default_nettype wire

// ===== hw/rtl/wsfe_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfe_out_stage
// Result register: holds one encoded byte while the downstream side stalls.
// ----------------------------------------------------------------------------
module wsfe_out_stage (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             res_valid,
    input  wire wsfe_pkg::res_t                   res,
    output logic                                  res_ready,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_byte[7:0]
    output logic [wsfe_pkg::M_DATA_BITS-1:0]      m_tdata,
    output logic                                  m_tlast,
    // error[0]
    output logic                                  m_tuser
);
    import wsfe_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign res_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = res_reg.out_byte;
    assign m_tlast   = res_reg.last;
    assign m_tuser   = res_reg.error;

    always_comb begin
        valid_next = valid_reg;
        if (res_ready) begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/websocket_frame_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_encoder
// Encodes WebSocket frames as a byte stream: header, optional key, masked
// payload.
//
//   channel | dir | tdata                                  | tuser | tlast
//   s_      | in  | opcode, final_flag, length, key, byte  | cmd   | -
//   m_      | out | out_byte                               | error | last
//
// A payload request yields one output byte; a begin request yields its
// header bytes (2 to 14), walked by the header byte sequencer.
// Data passes through the input register, then the result register.
// Reset clears both valid flags and the frame state (no frame open).
// m_tready low on a full result reg stalls the sequencer and s_tready at once.
// ----------------------------------------------------------------------------
module websocket_frame_encoder (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // opcode[3:0], final_flag[4], frame_length[36:5], mask_key[68:37],
    // payload_byte[76:69], zero fill[79:77]
    input  wire logic [wsfe_pkg::S_DATA_BITS-1:0] s_tdata,
    // cmd[0]
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_byte[7:0]
    output logic [wsfe_pkg::M_DATA_BITS-1:0]      m_tdata,
    output logic                                  m_tlast,
    // error[0]
    output logic                                  m_tuser
);
    import wsfe_pkg::*;

    logic  item_valid;
    item_t item;
    logic  item_pop;
    logic  res_valid;
    res_t  res;
    logic  res_ready;

    wsfe_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    wsfe_encoder u_encoder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    wsfe_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire
